>>> hdl/pmoa_pkg.sv
// Shared widths, register indexes, reset values and types of the marker pose averager.
`default_nettype none
package pmoa_pkg;

    // field widths
    localparam int ID_W    = 6;
    localparam int TRANS_W = 21;
    localparam int ROT_W   = 19;
    localparam int TTOL_W  = 20;
    localparam int RTOL_W  = 19;
    localparam int CNT_W   = 8;

    // running sums and mean/deviation widths
    localparam int TSUM_W  = 29;
    localparam int RSUM_W  = 27;
    localparam int SUM_W   = TSUM_W;
    localparam int MEAN_W  = TRANS_W;
    localparam int DIFF_W  = MEAN_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int NUM_DIFF = 6;

    // stream packing
    localparam int TDATA_W  = 3 * TRANS_W + 3 * ROT_W;
    localparam int S_TUSER_W = ID_W;
    localparam int M_TUSER_W = ID_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TTOL_W;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RTOL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 2'd3;

    localparam logic [ID_W-1:0]   RST_TARGET = 6'd0;
    localparam logic [TTOL_W-1:0] RST_TTOL   = 20'd1966;
    localparam logic [RTOL_W-1:0] RST_RTOL   = 19'd6554;
    localparam logic [CNT_W-1:0]  RST_MAX    = 8'd100;

    // status from the squared-norm unit to the controller
    typedef struct packed {
        logic done;
        logic pass;
    } t_norm_stat;

endpackage
`default_nettype wire

>>> hdl/marker_pose_outlier_averager.sv
// Top level of the marker pose outlier averager: control, state, config and stream ports.
//
// Each input beat carries one marker pose. Poses whose id differs from target_marker
// pass through raw. A pose of the target id is taken in S_IDLE; when the sums are empty
// they are seeded on the accept edge. Then S_LOAD starts the dividers, and in S_DIV six
// parallel bit-serial dividers form the truncated mean (21 quotient bits, one per cycle).
// Then the serial squared-norm unit runs in S_NORM (one 22x22 product per cycle over six
// deviations and two tolerances), S_OUT loads the output register, and the next beat is
// taken back in S_IDLE. While the output register still holds an untaken result, the
// block waits in S_OUT before loading it. The output register holds a result until it is
// taken while the block goes on. Configuration writes take effect at once and are meant
// for idle periods. m_tuser bit 6 is high when the output is the frozen mean.
`default_nettype none
module marker_pose_outlier_averager import pmoa_pkg::*; (
    input  wire  logic                  i_clk,
    input  wire  logic                  i_rst_n,
    // slave side
    input  wire  logic                  i_s_tvalid,
    output logic                        o_s_tready,
    // trans_x[20:0], trans_y[41:21], trans_z[62:42], rot_x[81:63], rot_y[100:82],
    // rot_z[119:101]
    input  wire  logic [TDATA_W-1:0]    i_s_tdata,
    // marker_id[5:0]
    input  wire  logic [S_TUSER_W-1:0]  i_s_tuser,
    // master side
    output logic                        o_m_tvalid,
    input  wire  logic                  i_m_tready,
    // out_trans_x[20:0], out_trans_y[41:21], out_trans_z[62:42], out_rot_x[81:63],
    // out_rot_y[100:82], out_rot_z[119:101]
    output logic [TDATA_W-1:0]          o_m_tdata,
    // out_marker_id[5:0], is_averaged[6]
    output logic [M_TUSER_W-1:0]        o_m_tuser,
    // configuration
    input  wire  logic                  i_cfg_we,
    input  wire  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam int DIV_STEPS = MEAN_W;
    localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);

    logic [2:0]                r_state;
    logic [DSTEP_W-1:0]        r_dstep;

    logic [ID_W-1:0]           r_target;
    logic [TTOL_W-1:0]         r_ttol;
    logic [RTOL_W-1:0]         r_rtol;
    logic [CNT_W-1:0]          r_max;

    logic [ID_W-1:0]           r_id;
    logic signed [TRANS_W-1:0] r_t [3];
    logic signed [ROT_W-1:0]   r_r [3];
    logic                      r_avg;

    logic signed [TSUM_W-1:0]  r_tsum [3];
    logic signed [RSUM_W-1:0]  r_rsum [3];
    logic [CNT_W-1:0]          r_count;

    logic                      r_m_valid;
    logic [TDATA_W-1:0]        r_m_tdata;
    logic [M_TUSER_W-1:0]      r_m_tuser;

    logic                      w_accept;
    logic                      w_lane_start;
    logic                      w_lane_step;
    logic                      w_norm_start;
    logic                      w_out_load;
    logic signed [SUM_W-1:0]   w_lane_sum  [NUM_DIFF];
    logic signed [MEAN_W-1:0]  w_mean      [NUM_DIFF];
    logic signed [DIFF_W-1:0]  w_diff      [NUM_DIFF];
    logic signed [MEAN_W-1:0]  w_pose      [NUM_DIFF];
    t_norm_stat                w_nstat;

    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_lane_start = (r_state == S_LOAD);
    assign w_lane_step  = (r_state == S_DIV) && (r_dstep < DSTEP_W'(DIV_STEPS));
    assign w_norm_start = (r_state == S_DIV) && (r_dstep == DSTEP_W'(DIV_STEPS));
    assign w_out_load   = (r_state == S_OUT) && (!r_m_valid || i_m_tready);

    // lanes see the sums widened to the divider width, and the pose widened to the mean
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_lane_sum[k]     = r_tsum[k];
            w_lane_sum[k + 3] = SUM_W'(r_rsum[k]);
            w_pose[k]         = r_t[k];
            w_pose[k + 3]     = MEAN_W'(r_r[k]);
        end
        for (int k = 0; k < NUM_DIFF; k++) begin
            w_diff[k] = DIFF_W'(w_mean[k]) - DIFF_W'(w_pose[k]);
        end
    end

    // six mean dividers, all stepping together
    for (genvar g = 0; g < NUM_DIFF; g++) begin : g_lane
        pmoa_div_lane u_lane (
            .i_clk   (i_clk),
            .i_start (w_lane_start),
            .i_step  (w_lane_step),
            .i_sum   (w_lane_sum[g]),
            .i_div   (r_count),
            .o_mean  (w_mean[g])
        );
    end

    pmoa_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_norm_start),
        .i_diff  (w_diff),
        .i_ttol  (r_ttol),
        .i_rtol  (r_rtol),
        .o_stat  (w_nstat)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= RST_TARGET;
            r_ttol   <= RST_TTOL;
            r_rtol   <= RST_RTOL;
            r_max    <= RST_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET: r_target <= i_cfg_data[ID_W-1:0];
                CFG_TTOL:   r_ttol   <= i_cfg_data[TTOL_W-1:0];
                CFG_RTOL:   r_rtol   <= i_cfg_data[RTOL_W-1:0];
                CFG_MAX:    r_max    <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dstep <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= (i_s_tuser == r_target) ? S_LOAD : S_OUT;
                    end
                end
                S_LOAD: begin
                    r_dstep <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dstep <= r_dstep + DSTEP_W'(1);
                    if (w_norm_start) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (w_nstat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // running sums and count; first sample seeds them on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_tsum[k] <= '0;
                r_rsum[k] <= '0;
            end
            r_count <= '0;
        end else if (w_accept && (i_s_tuser == r_target) && (r_count == '0)) begin
            for (int k = 0; k < 3; k++) begin
                r_tsum[k] <= TSUM_W'($signed(i_s_tdata[k*TRANS_W +: TRANS_W]));
                r_rsum[k] <= RSUM_W'($signed(i_s_tdata[3*TRANS_W + k*ROT_W +: ROT_W]));
            end
            r_count <= CNT_W'(1);
        end else if ((r_state == S_NORM) && w_nstat.done) begin
            if (!w_nstat.pass) begin
                for (int k = 0; k < 3; k++) begin
                    r_tsum[k] <= TSUM_W'(r_t[k]);
                    r_rsum[k] <= RSUM_W'(r_r[k]);
                end
                r_count <= CNT_W'(1);
            end else if (r_count < r_max) begin
                for (int k = 0; k < 3; k++) begin
                    r_tsum[k] <= r_tsum[k] + TSUM_W'(r_t[k]);
                    r_rsum[k] <= r_rsum[k] + RSUM_W'(r_r[k]);
                end
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // pose held for the work; replaced by the frozen mean when averaged
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id  <= i_s_tuser;
            r_avg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= $signed(i_s_tdata[k*TRANS_W +: TRANS_W]);
                r_r[k] <= $signed(i_s_tdata[3*TRANS_W + k*ROT_W +: ROT_W]);
            end
        end else if ((r_state == S_NORM) && w_nstat.done && w_nstat.pass
                     && !(r_count < r_max)) begin
            r_avg <= 1'b1;
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= w_mean[k];
                r_r[k] <= ROT_W'(w_mean[k + 3]);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_tdata <= {r_r[2], r_r[1], r_r[0], r_t[2], r_t[1], r_t[0]};
            r_m_tuser <= {r_avg, r_id};
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule
`default_nettype wire

>>> hdl/pmoa_div_lane.sv
// One lane of the bit-serial mean divider: |sum| / count, one quotient bit per cycle while i_step is high.
`default_nettype none
module pmoa_div_lane import pmoa_pkg::*; (
    input  wire  logic                     i_clk,
    input  wire  logic                     i_start,
    input  wire  logic                     i_step,
    input  wire  logic signed [SUM_W-1:0]  i_sum,
    input  wire  logic [CNT_W-1:0]         i_div,
    output logic signed [MEAN_W-1:0]       o_mean
);

    logic [SUM_W-1:0]  w_mag;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    logic              r_neg;
    logic [CNT_W-1:0]  r_rem;
    logic [MEAN_W-1:0] r_quo;

    // magnitude of the sum; the mean is known to fit MEAN_W bits, so the
    // high bits seed the partial remainder directly
    assign w_mag   = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign w_trial = {r_rem, r_quo[MEAN_W-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_ge    = (w_trial >= {1'b0, i_div});

    // restoring division step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_sum[SUM_W-1];
            r_rem <= w_mag[SUM_W-1:MEAN_W];
            r_quo <= w_mag[MEAN_W-1:0];
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_quo <= {r_quo[MEAN_W-2:0], w_ge};
        end
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign o_mean = r_neg ? (-$signed(r_quo)) : $signed(r_quo);

endmodule
`default_nettype wire

>>> hdl/pmoa_norm.sv
// Serial squared-norm unit: squares six deviations and two tolerances, then compares.
`default_nettype none
module pmoa_norm import pmoa_pkg::*; (
    input  wire  logic                     i_clk,
    input  wire  logic                     i_rst_n,
    input  wire  logic                     i_start,
    input  wire  logic signed [DIFF_W-1:0] i_diff [NUM_DIFF],
    input  wire  logic [TTOL_W-1:0]        i_ttol,
    input  wire  logic [RTOL_W-1:0]        i_rtol,
    output t_norm_stat                     o_stat
);

    localparam int NUM_OPS = NUM_DIFF + 2;
    localparam int STEP_W  = $clog2(NUM_OPS + 1);

    logic                     r_busy;
    logic                     r_done;
    logic [STEP_W-1:0]        r_step;
    logic [SQ_W-1:0]          r_prod;
    logic [SQ_W-1:0]          r_dt;
    logic [SQ_W-1:0]          r_dr;
    logic [SQ_W-1:0]          r_tt;
    logic [SQ_W-1:0]          r_rt;

    logic signed [DIFF_W-1:0] w_op;
    logic signed [SQ_W-1:0]   w_sq;
    logic [STEP_W-1:0]        w_prev;

    // operand select: deviations first, then the two tolerances
    always_comb begin
        case (r_step)
            STEP_W'(NUM_DIFF):     w_op = $signed({{(DIFF_W-TTOL_W){1'b0}}, i_ttol});
            STEP_W'(NUM_DIFF + 1): w_op = $signed({{(DIFF_W-RTOL_W){1'b0}}, i_rtol});
            default: begin
                if (r_step < STEP_W'(NUM_DIFF)) begin
                    w_op = i_diff[r_step[STEP_W-2:0]];
                end else begin
                    w_op = '0;
                end
            end
        endcase
    end

    assign w_sq   = w_op * w_op;
    assign w_prev = r_step - STEP_W'(1);

    // control: one product per cycle, accumulated in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(NUM_OPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // multiplier register, the two deviation accumulators and the two squared tolerances
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dt <= '0;
            r_dr <= '0;
            r_tt <= '0;
            r_rt <= '0;
        end else if (r_busy) begin
            r_prod <= SQ_W'(w_sq);
            if (r_step != '0) begin
                if (w_prev < STEP_W'(3)) begin
                    r_dt <= r_dt + r_prod;
                end else if (w_prev < STEP_W'(NUM_DIFF)) begin
                    r_dr <= r_dr + r_prod;
                end else if (w_prev == STEP_W'(NUM_DIFF)) begin
                    r_tt <= r_prod;
                end else begin
                    r_rt <= r_prod;
                end
            end
        end
    end

    // strict compare against both squared tolerances
    assign o_stat.done = r_done;
    assign o_stat.pass = (r_dt < r_tt) && (r_dr < r_rt);

endmodule
`default_nettype wire
